// ----- rtl/gfla_pkg.sv -----
//------------------------------------------------------------------------------
// gfla_pkg
// Shared constants, types and table builders for the GF(2^m) log/antilog ALU.
//------------------------------------------------------------------------------
`default_nettype none

package gfla_pkg;

   localparam int ELEM_W         = 8;
   localparam int CMD_W          = 3;
   localparam int EXP_W          = 32;
   localparam int DEF_FIELD_BITS = 8;
   localparam int DEF_FIELD_POLY = 285;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_INV = 3'd4,
      CMD_POW = 3'd5
   } cmd_type;

   typedef logic [255:0][ELEM_W-1:0] gf_table_type;

   // Payload leaving the operand/exponent front end.
   typedef struct packed {
      logic              valid;
      logic [CMD_W-1:0]  cmd;
      logic              a_nz;
      logic              b_nz;
      logic [ELEM_W-1:0] xorv;
      logic [ELEM_W-1:0] la;
      logic [ELEM_W-1:0] lidx;
      logic              eneg;
      logic              ezero;
      logic [ELEM_W-1:0] emod;
   } front_out_type;

   // Payload leaving the exponent multiply and result selection.
   typedef struct packed {
      logic              valid;
      logic              use_tab;
      logic [ELEM_W-1:0] idx;
      logic [ELEM_W-1:0] direct;
      logic              err;
   } mid_out_type;

   // Powers of alpha for i = 0 .. 2^m-2; remaining entries are zero.
   function automatic gf_table_type build_antilog(int m, int poly);
      gf_table_type t;
      logic [8:0]   v;
      logic [8:0]   mask;
      int           order;
      t     = '0;
      v     = 9'd1;
      mask  = 9'((1 << m) - 1);
      order = (1 << m) - 1;
      for (int i = 0; i < 255; i++) begin
         if (i < order) begin
            t[i] = 8'(v & mask);
            v    = v << 1;
            if (v[m]) begin
               v = v ^ 9'(poly);
            end
            v = v & mask;
         end
      end
      return t;
   endfunction

   // Discrete log; the lowest exponent wins when the polynomial repeats values.
   function automatic gf_table_type build_log(int m, int poly);
      gf_table_type t;
      gf_table_type alog;
      int           order;
      t     = '0;
      alog  = build_antilog(m, poly);
      order = (1 << m) - 1;
      for (int i = 254; i >= 0; i--) begin
         if (i < order) begin
            t[alog[i]] = 8'(i);
         end
      end
      t[0] = '0;
      return t;
   endfunction

   // Sum of the m-bit digits of a 32-bit word (congruent modulo 2^m-1).
   function automatic logic [15:0] digit_sum(logic [31:0] x, int m);
      logic [15:0] s;
      logic [31:0] f;
      s = '0;
      f = 32'((1 << m) - 1);
      for (int d = 0; d < 32; d++) begin
         if (d * m < 32) begin
            s = s + 16'((x >> (d * m)) & f);
         end
      end
      return s;
   endfunction

   // Reduction modulo 2^m-1 of a small value by end-around folding.
   function automatic logic [15:0] fold_mod(logic [15:0] x, int m);
      logic [15:0] f;
      logic [15:0] r;
      f = 16'((1 << m) - 1);
      r = x;
      if (m < 2) begin
         r = '0;
      end else begin
         for (int k = 0; k < 6; k++) begin
            r = (r & f) + (r >> m);
         end
         if (r >= f) begin
            r = r - f;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/gfla_if.sv -----
//------------------------------------------------------------------------------
// gfla_req_if / gfla_rsp_if
// Valid/ready channels for the GF(2^m) ALU request and response transactions.
//------------------------------------------------------------------------------
`default_nettype none

interface gfla_req_if;
   logic                                valid;
   logic                                ready;
   logic [gfla_pkg::CMD_W-1:0]          command;
   logic [gfla_pkg::ELEM_W-1:0]         operand_a;
   logic [gfla_pkg::ELEM_W-1:0]         operand_b;
   logic signed [gfla_pkg::EXP_W-1:0]   exponent;

   modport source (output valid, command, operand_a, operand_b, exponent, input ready);
   modport sink   (input valid, command, operand_a, operand_b, exponent, output ready);
endinterface

interface gfla_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gfla_pkg::ELEM_W-1:0] result_value;
   logic [gfla_pkg::ELEM_W-1:0] result_log;
   logic                        error;

   modport source (output valid, result_value, result_log, error, input ready);
   modport sink   (input valid, result_value, result_log, error, output ready);
endinterface

`default_nettype wire

// ----- rtl/gfla_front.sv -----
//------------------------------------------------------------------------------
// gfla_front
// Log lookups, exponent magnitude, digit sum and reduction modulo 2^m-1.
//------------------------------------------------------------------------------
`default_nettype none

module gfla_front #(
   parameter int FIELD_BITS = gfla_pkg::DEF_FIELD_BITS,
   parameter int FIELD_POLY = gfla_pkg::DEF_FIELD_POLY
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [gfla_pkg::CMD_W-1:0]          command,
   input  wire logic [gfla_pkg::ELEM_W-1:0]         operand_a,
   input  wire logic [gfla_pkg::ELEM_W-1:0]         operand_b,
   input  wire logic signed [gfla_pkg::EXP_W-1:0]   exponent,
   output gfla_pkg::front_out_type                  out,
   input  wire logic                                out_ready
);

   localparam int FB    = FIELD_BITS;
   localparam int ORDER = (1 << FB) - 1;
   localparam int NDIG  = (gfla_pkg::EXP_W + FB - 1) / FB;
   localparam int SUM_W = FB + $clog2(NDIG + 1);
   localparam logic [FB:0] ORDER_X = (FB + 1)'(ORDER);
   localparam gfla_pkg::gf_table_type LOG = gfla_pkg::build_log(FB, FIELD_POLY);

   logic adv1, adv2, adv3;

   // Stage 1 registers.
   logic                   s1_v_ff;
   logic [2:0]             s1_cmd_ff;
   logic [FB-1:0]          s1_a_ff, s1_b_ff, s1_la_ff, s1_lb_ff;
   logic [31:0]            s1_emag_ff;
   logic                   s1_eneg_ff, s1_ezero_ff;
   logic [FB-1:0]          s1_a_in, s1_b_in;
   logic [31:0]            e_raw, s1_emag_in;

   // Stage 2 registers.
   logic                   s2_v_ff;
   logic [2:0]             s2_cmd_ff;
   logic                   s2_a_nz_ff, s2_b_nz_ff, s2_eneg_ff, s2_ezero_ff;
   logic [FB-1:0]          s2_xorv_ff, s2_la_ff, s2_lidx_ff, s2_lidx_in;
   logic [SUM_W-1:0]       s2_dsum_ff;
   logic [15:0]            dsum_full;
   logic [FB:0]            lsum, ldif, linv;

   // Stage 3 registers.
   logic                   s3_v_ff;
   logic [2:0]             s3_cmd_ff;
   logic                   s3_a_nz_ff, s3_b_nz_ff, s3_eneg_ff, s3_ezero_ff;
   logic [FB-1:0]          s3_xorv_ff, s3_la_ff, s3_lidx_ff, s3_emod_ff;
   logic [15:0]            emod_full;

   assign adv3     = !s3_v_ff || out_ready;
   assign adv2     = !s2_v_ff || adv3;
   assign adv1     = !s1_v_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      s1_a_in    = operand_a[FB-1:0];
      s1_b_in    = operand_b[FB-1:0];
      e_raw      = exponent;
      s1_emag_in = e_raw[31] ? (~e_raw + 32'd1) : e_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv1) begin
         s1_v_ff <= in_valid;
      end
      if (adv1) begin
         s1_cmd_ff   <= command;
         s1_a_ff     <= s1_a_in;
         s1_b_ff     <= s1_b_in;
         s1_la_ff    <= LOG[8'(s1_a_in)][FB-1:0];
         s1_lb_ff    <= LOG[8'(s1_b_in)][FB-1:0];
         s1_emag_ff  <= s1_emag_in;
         s1_eneg_ff  <= e_raw[31];
         s1_ezero_ff <= (e_raw == 32'd0);
      end
   end

   // Log of the product, quotient or inverse; both logs are below the order.
   always_comb begin
      dsum_full = gfla_pkg::digit_sum(s1_emag_ff, FB);
      lsum      = {1'b0, s1_la_ff} + {1'b0, s1_lb_ff};
      ldif      = {1'b0, s1_la_ff} + ORDER_X - {1'b0, s1_lb_ff};
      linv      = ORDER_X - {1'b0, s1_la_ff};
      case (s1_cmd_ff)
         gfla_pkg::CMD_MUL: s2_lidx_in = (lsum >= ORDER_X) ? FB'(lsum - ORDER_X) : FB'(lsum);
         gfla_pkg::CMD_DIV: s2_lidx_in = (ldif >= ORDER_X) ? FB'(ldif - ORDER_X) : FB'(ldif);
         default:           s2_lidx_in = (linv >= ORDER_X) ? '0 : FB'(linv);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv2) begin
         s2_v_ff <= s1_v_ff;
      end
      if (adv2) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_a_nz_ff  <= (s1_a_ff != '0);
         s2_b_nz_ff  <= (s1_b_ff != '0);
         s2_xorv_ff  <= s1_a_ff ^ s1_b_ff;
         s2_la_ff    <= s1_la_ff;
         s2_lidx_ff  <= s2_lidx_in;
         s2_eneg_ff  <= s1_eneg_ff;
         s2_ezero_ff <= s1_ezero_ff;
         s2_dsum_ff  <= dsum_full[SUM_W-1:0];
      end
   end

   assign emod_full = gfla_pkg::fold_mod(16'(s2_dsum_ff), FB);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv3) begin
         s3_v_ff <= s2_v_ff;
      end
      if (adv3) begin
         s3_cmd_ff   <= s2_cmd_ff;
         s3_a_nz_ff  <= s2_a_nz_ff;
         s3_b_nz_ff  <= s2_b_nz_ff;
         s3_xorv_ff  <= s2_xorv_ff;
         s3_la_ff    <= s2_la_ff;
         s3_lidx_ff  <= s2_lidx_ff;
         s3_eneg_ff  <= s2_eneg_ff;
         s3_ezero_ff <= s2_ezero_ff;
         s3_emod_ff  <= emod_full[FB-1:0];
      end
   end

   always_comb begin
      out.valid = s3_v_ff;
      out.cmd   = s3_cmd_ff;
      out.a_nz  = s3_a_nz_ff;
      out.b_nz  = s3_b_nz_ff;
      out.xorv  = 8'(s3_xorv_ff);
      out.la    = 8'(s3_la_ff);
      out.lidx  = 8'(s3_lidx_ff);
      out.eneg  = s3_eneg_ff;
      out.ezero = s3_ezero_ff;
      out.emod  = 8'(s3_emod_ff);
   end

endmodule

`default_nettype wire

// ----- rtl/gfla_expmul.sv -----
//------------------------------------------------------------------------------
// gfla_expmul
// Exponent times log product, its reduction, and per-command result selection.
//------------------------------------------------------------------------------
`default_nettype none

module gfla_expmul #(
   parameter int FIELD_BITS = gfla_pkg::DEF_FIELD_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire gfla_pkg::front_out_type in,
   output logic                         in_ready,
   output gfla_pkg::mid_out_type        out,
   input  wire logic                    out_ready
);

   localparam int FB    = FIELD_BITS;
   localparam int ORDER = (1 << FB) - 1;

   logic adv4, adv5;

   logic                s4_v_ff;
   logic [2:0]          s4_cmd_ff;
   logic                s4_a_nz_ff, s4_b_nz_ff, s4_eneg_ff, s4_ezero_ff;
   logic [FB-1:0]       s4_xorv_ff, s4_lidx_ff;
   logic [2*FB-1:0]     s4_prod_ff;

   logic                s5_v_ff, s5_use_tab_ff, s5_err_ff;
   logic [FB-1:0]       s5_idx_ff, s5_direct_ff;
   logic                s5_use_tab_in, s5_err_in;
   logic [FB-1:0]       s5_idx_in, s5_direct_in;
   logic [15:0]         pmod_full;
   logic [FB-1:0]       pmod, pow_idx;

   assign adv5     = !s5_v_ff || out_ready;
   assign adv4     = !s4_v_ff || adv5;
   assign in_ready = adv4;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv4) begin
         s4_v_ff <= in.valid;
      end
      if (adv4) begin
         s4_cmd_ff   <= in.cmd;
         s4_a_nz_ff  <= in.a_nz;
         s4_b_nz_ff  <= in.b_nz;
         s4_eneg_ff  <= in.eneg;
         s4_ezero_ff <= in.ezero;
         s4_xorv_ff  <= in.xorv[FB-1:0];
         s4_lidx_ff  <= in.lidx[FB-1:0];
         s4_prod_ff  <= (2*FB)'(in.emod[FB-1:0]) * (2*FB)'(in.la[FB-1:0]);
      end
   end

   always_comb begin
      pmod_full = gfla_pkg::fold_mod(16'(s4_prod_ff), FB);
      pmod      = pmod_full[FB-1:0];
      // A negative exponent negates the log modulo the group order.
      pow_idx   = (s4_eneg_ff && pmod != '0) ? FB'(ORDER) - pmod : pmod;

      s5_use_tab_in = 1'b0;
      s5_idx_in     = s4_lidx_ff;
      s5_direct_in  = '0;
      s5_err_in     = 1'b0;
      case (s4_cmd_ff) inside
         gfla_pkg::CMD_ADD, gfla_pkg::CMD_SUB: begin
            s5_direct_in = s4_xorv_ff;
         end
         gfla_pkg::CMD_MUL: begin
            s5_use_tab_in = s4_a_nz_ff && s4_b_nz_ff;
         end
         gfla_pkg::CMD_DIV: begin
            s5_err_in     = !s4_b_nz_ff;
            s5_use_tab_in = s4_b_nz_ff && s4_a_nz_ff;
         end
         gfla_pkg::CMD_INV: begin
            s5_err_in     = !s4_a_nz_ff;
            s5_use_tab_in = s4_a_nz_ff;
         end
         gfla_pkg::CMD_POW: begin
            s5_idx_in = pow_idx;
            if (s4_a_nz_ff) begin
               s5_use_tab_in = 1'b1;
            end else if (s4_ezero_ff) begin
               s5_direct_in = FB'(1);
            end else begin
               s5_err_in = s4_eneg_ff;
            end
         end
         default: begin
            s5_err_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv5) begin
         s5_v_ff <= s4_v_ff;
      end
      if (adv5) begin
         s5_use_tab_ff <= s5_use_tab_in;
         s5_idx_ff     <= s5_idx_in;
         s5_direct_ff  <= s5_direct_in;
         s5_err_ff     <= s5_err_in;
      end
   end

   always_comb begin
      out.valid   = s5_v_ff;
      out.use_tab = s5_use_tab_ff;
      out.idx     = 8'(s5_idx_ff);
      out.direct  = 8'(s5_direct_ff);
      out.err     = s5_err_ff;
   end

endmodule

`default_nettype wire

// ----- rtl/gfla_back.sv -----
//------------------------------------------------------------------------------
// gfla_back
// Antilog lookup of the result, then its log form in the output register.
//------------------------------------------------------------------------------
`default_nettype none

module gfla_back #(
   parameter int FIELD_BITS = gfla_pkg::DEF_FIELD_BITS,
   parameter int FIELD_POLY = gfla_pkg::DEF_FIELD_POLY
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire gfla_pkg::mid_out_type       in,
   output logic                             in_ready,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [gfla_pkg::ELEM_W-1:0]      out_value,
   output logic [gfla_pkg::ELEM_W-1:0]      out_log,
   output logic                             out_err
);

   localparam int FB = FIELD_BITS;
   localparam gfla_pkg::gf_table_type ANTILOG = gfla_pkg::build_antilog(FB, FIELD_POLY);
   localparam gfla_pkg::gf_table_type LOG     = gfla_pkg::build_log(FB, FIELD_POLY);

   logic adv6, adv7;

   logic          s6_v_ff, s6_err_ff;
   logic [FB-1:0] s6_value_ff, s6_value_in;

   logic          s7_v_ff, s7_err_ff;
   logic [FB-1:0] s7_value_ff, s7_log_ff;

   assign adv7     = !s7_v_ff || out_ready;
   assign adv6     = !s6_v_ff || adv7;
   assign in_ready = adv6;

   assign s6_value_in = in.use_tab ? ANTILOG[in.idx][FB-1:0] : in.direct[FB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv6) begin
         s6_v_ff <= in.valid;
      end
      if (adv6) begin
         s6_value_ff <= s6_value_in;
         s6_err_ff   <= in.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv7) begin
         s7_v_ff <= s6_v_ff;
      end
      if (adv7) begin
         s7_value_ff <= s6_value_ff;
         s7_log_ff   <= LOG[8'(s6_value_ff)][FB-1:0];
         s7_err_ff   <= s6_err_ff;
      end
   end

   assign out_valid = s7_v_ff;
   assign out_value = 8'(s7_value_ff);
   assign out_log   = 8'(s7_log_ff);
   assign out_err   = s7_err_ff;

endmodule

`default_nettype wire

// ----- rtl/galois_field_log_alu_top.sv -----
//------------------------------------------------------------------------------
// galois_field_log_alu_top
// Pipelined GF(2^m) arithmetic unit using log and antilog tables.
//------------------------------------------------------------------------------
// Requests arrive on req_chan as valid/ready transactions carrying a command
// (add, subtract, multiply, divide, inverse, power), two field elements and a
// signed 32-bit exponent. Each request yields exactly one response on rsp_chan
// with the result element, its discrete log and an error flag.
// The datapath is a seven-stage pipeline: log lookups, exponent digit sum,
// reduction modulo 2^m-1, exponent times log multiply, product reduction and
// result selection, antilog lookup, and log lookup into the output register.
// One transaction can be accepted every cycle while rsp_chan.ready does not
// stall the pipeline. The depth is set by the exponent reduction and the
// multiplier that must each sit between their own registers.
// Synchronous reset clears all stage valid bits; no transaction is in flight
// afterwards, and the tables are constants, so no warm-up time is needed.
// When the receiver holds rsp_chan.ready low, the output stage holds its
// transaction and stalls fill any empty stages before req_chan.ready drops.
//------------------------------------------------------------------------------
`default_nettype none

module galois_field_log_alu_top #(
   parameter int FIELD_BITS = gfla_pkg::DEF_FIELD_BITS,
   parameter int FIELD_POLY = gfla_pkg::DEF_FIELD_POLY
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gfla_req_if.sink    req_chan,
   gfla_rsp_if.source  rsp_chan
);

   gfla_pkg::front_out_type front_out;
   gfla_pkg::mid_out_type   mid_out;
   logic                    front_ready, mid_ready, back_ready;

   gfla_front #(
      .FIELD_BITS (FIELD_BITS),
      .FIELD_POLY (FIELD_POLY)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (front_ready),
      .command   (req_chan.command),
      .operand_a (req_chan.operand_a),
      .operand_b (req_chan.operand_b),
      .exponent  (req_chan.exponent),
      .out       (front_out),
      .out_ready (mid_ready)
   );

   gfla_expmul #(
      .FIELD_BITS (FIELD_BITS)
   ) u_expmul (
      .clock     (clock),
      .reset     (reset),
      .in        (front_out),
      .in_ready  (mid_ready),
      .out       (mid_out),
      .out_ready (back_ready)
   );

   gfla_back #(
      .FIELD_BITS (FIELD_BITS),
      .FIELD_POLY (FIELD_POLY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in        (mid_out),
      .in_ready  (back_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_value (rsp_chan.result_value),
      .out_log   (rsp_chan.result_log),
      .out_err   (rsp_chan.error)
   );

   assign req_chan.ready = front_ready;

endmodule

`default_nettype wire
